FILE: rtl/tmie_pkg.sv
// ----------------------------------------------------------------------------
// tmie_pkg
// Shared constants, types and helpers of the tape machine instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package tmie_pkg;

  localparam int TAPE_CELLS = 32768;
  localparam int PTR_W      = (TAPE_CELLS > 2) ? $clog2(TAPE_CELLS) : 1;
  localparam int SUM_W      = PTR_W + 9;
  localparam int FUNC_W     = 4;
  localparam int ERR_W      = 3;
  localparam int TGT_W      = 32;
  localparam int PFIELD_W   = 15;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [7:0]          cell_t;
  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [ERR_W-1:0]    err_t;
  typedef logic [TGT_W-1:0]    tgt_t;
  typedef logic [PFIELD_W-1:0] pfield_t;

  localparam logic [SUM_W-1:0] TAPE_LIMIT = SUM_W'(TAPE_CELLS);
  localparam ptr_t             PTR_LAST   = PTR_W'(TAPE_CELLS - 1);

  // instruction codes
  localparam func_t FN_INCP  = 4'd0;
  localparam func_t FN_DECP  = 4'd1;
  localparam func_t FN_INCV  = 4'd2;
  localparam func_t FN_DECV  = 4'd3;
  localparam func_t FN_READ  = 4'd4;
  localparam func_t FN_WRITE = 4'd5;
  localparam func_t FN_JMPZ  = 4'd6;
  localparam func_t FN_JMPNZ = 4'd7;
  localparam func_t FN_DEBUG = 4'd8;
  localparam func_t FN_RET   = 4'd9;

  // sticky error codes
  localparam err_t ERR_NONE    = 3'd0;
  localparam err_t ERR_PTR_OVF = 3'd1;
  localparam err_t ERR_PTR_UNF = 3'd2;
  localparam err_t ERR_EOF     = 3'd3;
  localparam err_t ERR_INVALID = 3'd4;

  // instruction in flight between decode and the tape stage
  typedef struct packed {
    logic  active;   // error state was clear when accepted
    func_t func;
    cell_t amount;
    tgt_t  target;
    cell_t in_byte;
    logic  in_eof;
    ptr_t  ptr;      // pointer after the instruction
    err_t  err;      // error state after the instruction
  } exec_t;

  typedef struct packed {
    logic  en;
    ptr_t  addr;
    cell_t data;
  } tape_wr_t;

  typedef struct packed {
    logic    out_valid;
    cell_t   out_byte;
    logic    branch_taken;
    tgt_t    branch_target;
    err_t    error_code;
    logic    halted;
    pfield_t pointer;
    cell_t   cell_res;
  } res_t;

  // pointer as shown in the 15-bit result field
  function automatic pfield_t ptr_field(input ptr_t p);
    logic [PTR_W+PFIELD_W-1:0] w;
    w = '0;
    w[PTR_W-1:0] = p;
    return w[PFIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tmie_if.sv
// ----------------------------------------------------------------------------
// tmie_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmie_in_if;
  logic            valid;
  logic            ready;
  tmie_pkg::func_t func;
  tmie_pkg::cell_t amount;
  tmie_pkg::tgt_t  target;
  tmie_pkg::cell_t in_byte;
  logic            in_eof;

  modport source (output valid, func, amount, target, in_byte, in_eof, input ready);
  modport sink   (input valid, func, amount, target, in_byte, in_eof, output ready);
endinterface

interface tmie_out_if;
  logic              valid;
  logic              ready;
  logic              out_valid;
  tmie_pkg::cell_t   out_byte;
  logic              branch_taken;
  tmie_pkg::tgt_t    branch_target;
  tmie_pkg::err_t    error_code;
  logic              halted;
  tmie_pkg::pfield_t pointer;
  tmie_pkg::cell_t   cell_res;

  modport source (output valid, out_valid, out_byte, branch_taken, branch_target,
                  error_code, halted, pointer, cell_res, input ready);
  modport sink   (input valid, out_valid, out_byte, branch_taken, branch_target,
                  error_code, halted, pointer, cell_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/tmie_front.sv
// ----------------------------------------------------------------------------
// tmie_front
// Instruction decode with the data pointer and sticky error registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tmie_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire tmie_pkg::func_t func,
  input  wire tmie_pkg::cell_t amount,
  input  wire tmie_pkg::tgt_t  target,
  input  wire tmie_pkg::cell_t in_byte,
  input  wire logic            in_eof,
  output tmie_pkg::exec_t      exec
);
  import tmie_pkg::*;

  ptr_t             ptr;
  err_t             err;
  ptr_t             ptr_next;
  err_t             err_next;
  logic [SUM_W-1:0] sum;

  always_comb begin
    sum      = SUM_W'(ptr) + SUM_W'(amount);
    ptr_next = ptr;
    err_next = err;
    if (err == ERR_NONE) begin
      unique case (func) inside
        FN_INCP: begin
          if (sum >= TAPE_LIMIT) err_next = ERR_PTR_OVF;
          else                   ptr_next = sum[PTR_W-1:0];
        end
        FN_DECP: begin
          if (SUM_W'(ptr) < SUM_W'(amount)) err_next = ERR_PTR_UNF;
          else                              ptr_next = ptr - PTR_W'(amount);
        end
        FN_READ: begin
          if (in_eof) err_next = ERR_EOF;
        end
        FN_INCV, FN_DECV, FN_WRITE, FN_JMPZ, FN_JMPNZ, FN_DEBUG, FN_RET: begin
        end
        default: err_next = ERR_INVALID;
      endcase
    end
  end

  always_comb begin
    exec.active  = (err == ERR_NONE);
    exec.func    = func;
    exec.amount  = amount;
    exec.target  = target;
    exec.in_byte = in_byte;
    exec.in_eof  = in_eof;
    exec.ptr     = ptr_next;
    exec.err     = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      err <= ERR_NONE;
    end else if (accept) begin
      ptr <= ptr_next;
      err <= err_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tmie_tape.sv
// ----------------------------------------------------------------------------
// tmie_tape
// Byte tape memory with clearing sweep after reset and write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module tmie_tape (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tmie_pkg::ptr_t     rd_addr,
  input  wire tmie_pkg::tape_wr_t wr,
  output tmie_pkg::cell_t         rd_data,
  output logic                    busy
);
  import tmie_pkg::*;

  cell_t mem [TAPE_CELLS];
  cell_t mem_q;
  ptr_t  rd_addr_q;
  ptr_t  clr_addr;
  logic  we;
  ptr_t  wa;
  cell_t wd;
  logic  fwd_valid;
  ptr_t  fwd_addr;
  cell_t fwd_data;

  // clearing sweep owns the write port until done
  always_comb begin
    we = busy | wr.en;
    wa = busy ? clr_addr : wr.addr;
    wd = busy ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    fwd_addr  <= wa;
    fwd_data  <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= we;
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == PTR_LAST) busy <= 1'b0;
      end
    end
  end

  // a write in the read's own cycle is not seen by the array
  assign rd_data = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : mem_q;

endmodule

`default_nettype wire

FILE: rtl/tape_machine_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor_core
// Executes one decoded tape machine instruction per transaction.
// ----------------------------------------------------------------------------
// path: each instruction is held in the tape stage register while its cell is
//   read and modified, then its result goes to the result register
// throughput: one instruction per cycle while results are taken, set by one
//   tape read and one write per cycle on the single-port-write tape memory
// reset: pointer and error clear at once; the tape is then cleared one cell
//   per cycle, all TAPE_CELLS (32768) cells, while no instruction is taken
`default_nettype none

module tape_machine_instruction_executor_core (
  input  wire logic   clk,
  input  wire logic   rst,
  tmie_in_if.sink     instr,
  tmie_out_if.source  result
);
  import tmie_pkg::*;

  exec_t    exec;
  exec_t    s1;
  logic     s1_valid;
  logic     s1_adv;
  logic     accept;
  logic     tape_busy;
  ptr_t     rd_addr;
  cell_t    rd_data;
  tape_wr_t wr;
  res_t     res_next;
  res_t     res;
  logic     res_valid;
  cell_t    cell_new;
  logic     cell_mod;

  // tape stage moves on when the result register is free or drains
  assign s1_adv      = s1_valid && (!res_valid || result.ready);
  assign instr.ready = !tape_busy && (!s1_valid || s1_adv);
  assign accept      = instr.valid && instr.ready;

  tmie_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (instr.func),
    .amount  (instr.amount),
    .target  (instr.target),
    .in_byte (instr.in_byte),
    .in_eof  (instr.in_eof),
    .exec    (exec)
  );

  // a stalled tape stage keeps re-reading its own cell
  assign rd_addr = (s1_valid && !s1_adv) ? s1.ptr : exec.ptr;

  tmie_tape u_tape (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data),
    .busy    (tape_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= exec;
  end

  // cell modify and result build
  always_comb begin
    cell_new               = rd_data;
    cell_mod               = 1'b0;
    res_next.out_valid     = 1'b0;
    res_next.out_byte      = '0;
    res_next.branch_taken  = 1'b0;
    res_next.branch_target = '0;
    res_next.halted        = 1'b0;
    if (s1.active) begin
      case (s1.func)
        FN_INCV: begin
          cell_new = rd_data + s1.amount;
          cell_mod = 1'b1;
        end
        FN_DECV: begin
          cell_new = rd_data - s1.amount;
          cell_mod = 1'b1;
        end
        FN_READ: begin
          if (!s1.in_eof) begin
            cell_new = s1.in_byte;
            cell_mod = 1'b1;
          end
        end
        FN_WRITE: begin
          res_next.out_valid = 1'b1;
          res_next.out_byte  = rd_data;
        end
        FN_JMPZ: begin
          if (rd_data == '0) begin
            res_next.branch_taken  = 1'b1;
            res_next.branch_target = s1.target;
          end
        end
        FN_JMPNZ: begin
          if (rd_data != '0) begin
            res_next.branch_taken  = 1'b1;
            res_next.branch_target = s1.target;
          end
        end
        FN_RET: res_next.halted = 1'b1;
        default: begin
        end
      endcase
    end
    res_next.error_code = s1.err;
    res_next.pointer    = ptr_field(s1.ptr);
    res_next.cell_res   = cell_new;
  end

  // write back only as the instruction leaves the tape stage
  always_comb begin
    wr.en   = s1_adv && cell_mod;
    wr.addr = s1.ptr;
    wr.data = cell_new;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) res <= res_next;
  end

  assign result.valid         = res_valid;
  assign result.out_valid     = res.out_valid;
  assign result.out_byte      = res.out_byte;
  assign result.branch_taken  = res.branch_taken;
  assign result.branch_target = res.branch_target;
  assign result.error_code    = res.error_code;
  assign result.halted        = res.halted;
  assign result.pointer       = res.pointer;
  assign result.cell_res      = res.cell_res;

  // no instruction while the tape is being cleared
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    tape_busy |-> !instr.ready)
    else $error("instruction accepted during tape clear");

  // a stalled tape stage keeps its instruction
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1.ptr) && $stable(s1.func)))
    else $error("tape stage lost a stalled instruction");

  // tape writes come only from live instructions
  a_wr_live: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (s1_valid && s1.active && s1.err == ERR_NONE))
    else $error("tape write from a dead instruction");

  // emitted bytes, branches and halts never carry an error
  a_out_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.out_valid || res.branch_taken || res.halted))
      |-> res.error_code == ERR_NONE)
    else $error("result flags set alongside an error");

endmodule

`default_nettype wire

FILE: tb/sv/tb_tape_machine_instruction_executor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tape_machine_instruction_executor_core
// Self-checking bench for the tape machine instruction executor. Instructions
// go in over a valid/ready channel with random gaps, results come back with
// random stalls, and each result is compared field by field with a tape,
// pointer and sticky-error model kept inside the bench. The run covers the
// operand extremes, a walk to the last cell and back, about two thousand
// legal random instructions, and one error that then sticks to the end.
// ----------------------------------------------------------------------------

module tb_tape_machine_instruction_executor_core;
  import tmie_pkg::*;

  // first code that the executor treats as an invalid instruction
  localparam func_t FN_INVALID_LO = 4'd10;
  localparam int    RANDOM_ITEMS  = 2000;
  localparam int    DRAIN_CYCLES  = 10;

  logic clk;
  logic rst;

  tmie_in_if  instr_if ();
  tmie_out_if res_if ();

  tape_machine_instruction_executor_core DUT (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_if),
    .result (res_if)
  );

  // tape, pointer and sticky error as the executor should hold them
  bit [7:0] tape_model [TAPE_CELLS];
  ptr_t     model_ptr;
  err_t     model_err;

  // results still owed by the executor, oldest first
  res_t expected_results [$];
  int   fault_count;
  // when set, neither side idles or stalls
  bit   steady_flow;

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // reset clears the whole tape first; the slowest run, every gap and stall at
  // its longest, stays inside the limit that this watchdog allows
  initial begin
    #4_000_000;
    $display("tape_machine_instruction_executor_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // gap lengths: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // --------------------------------------------------------------------------
  // executor model: apply one accepted instruction, queue its result
  // --------------------------------------------------------------------------
  task automatic execute_model(input func_t f, input cell_t amt, input tgt_t tgt,
                               input cell_t ib, input logic eof);
    res_t             r;
    ptr_t             p;
    logic [SUM_W-1:0] sum;
    r = '0;
    p = model_ptr;
    // once an error is latched nothing changes any more
    if (model_err == ERR_NONE) begin
      case (f)
        FN_INCP: begin
          sum = SUM_W'(p) + SUM_W'(amt);
          if (sum >= TAPE_CELLS) model_err = ERR_PTR_OVF;
          else p = sum[PTR_W-1:0];
        end
        FN_DECP: begin
          if (p < amt) model_err = ERR_PTR_UNF;
          else p = p - amt;
        end
        FN_INCV: tape_model[p] = tape_model[p] + amt;
        FN_DECV: tape_model[p] = tape_model[p] - amt;
        FN_READ: begin
          if (eof) model_err = ERR_EOF;
          else tape_model[p] = ib;
        end
        FN_WRITE: begin
          r.out_valid = 1'b1;
          r.out_byte  = tape_model[p];
        end
        FN_JMPZ: begin
          if (tape_model[p] == 8'd0) begin
            r.branch_taken  = 1'b1;
            r.branch_target = tgt;
          end
        end
        FN_JMPNZ: begin
          if (tape_model[p] != 8'd0) begin
            r.branch_taken  = 1'b1;
            r.branch_target = tgt;
          end
        end
        FN_DEBUG: ;
        FN_RET:   r.halted = 1'b1;
        default:  model_err = ERR_INVALID;
      endcase
      model_ptr = p;
    end
    r.error_code = model_err;
    r.pointer    = pfield_t'(model_ptr);
    r.cell_res   = tape_model[model_ptr];
    expected_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // instruction driver: called at a falling edge, returns at a falling edge;
  // valid stays high after the transaction so the next call can follow on
  // --------------------------------------------------------------------------
  task automatic send_instr(input func_t f, input cell_t amt, input tgt_t tgt,
                            input cell_t ib, input logic eof);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      instr_if.valid   <= 1'b0;
      instr_if.func    <= func_t'($urandom);
      instr_if.amount  <= cell_t'($urandom);
      instr_if.target  <= tgt_t'($urandom);
      instr_if.in_byte <= cell_t'($urandom);
      instr_if.in_eof  <= 1'($urandom);
      @(negedge clk);
    end
    instr_if.valid   <= 1'b1;
    instr_if.func    <= f;
    instr_if.amount  <= amt;
    instr_if.target  <= tgt;
    instr_if.in_byte <= ib;
    instr_if.in_eof  <= eof;
    do @(posedge clk); while (!instr_if.ready);
    execute_model(f, amt, tgt, ib, eof);
    @(negedge clk);
  endtask

  // drop valid; needed before any wait that is not a send
  task automatic idle_instr();
    instr_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold the sender until every owed result has come back
  task automatic wait_results_drained();
    idle_instr();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // operand pickers
  // --------------------------------------------------------------------------
  // pointer step within the room left and at most 255: mostly tiny, sometimes the most allowed
  function automatic cell_t pick_step(input int room);
    int lim;
    int r;
    lim = (room < 255) ? room : 255;
    r   = $urandom_range(0, 9);
    if (r < 6) return cell_t'($urandom_range(0, (lim < 3) ? lim : 3));
    if (r < 9) return cell_t'($urandom_range(0, lim));
    return cell_t'(lim);
  endfunction

  function automatic cell_t pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return cell_t'($urandom);
  endfunction

  function automatic tgt_t pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return tgt_t'($urandom);
  endfunction

  // one instruction that cannot raise an error in the current state
  task automatic send_legal_op();
    int    sel;
    func_t f;
    cell_t amt;
    logic  eof;
    sel = $urandom_range(0, 99);
    amt = pick_byte();
    eof = 1'($urandom);
    if (sel < 15) begin
      f   = FN_INCP;
      amt = pick_step(PTR_LAST - model_ptr);
    end else if (sel < 30) begin
      f   = FN_DECP;
      amt = pick_step(model_ptr);
    end else if (sel < 43) f = FN_INCV;
    else if (sel < 55) f = FN_DECV;
    else if (sel < 67) begin
      f   = FN_READ;
      eof = 1'b0;
    end else if (sel < 77) f = FN_WRITE;
    else if (sel < 83) f = FN_JMPZ;
    else if (sel < 89) f = FN_JMPNZ;
    else if (sel < 95) f = FN_DEBUG;
    else f = FN_RET;
    send_instr(f, amt, pick_target(), pick_byte(), eof);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // operand extremes, cell wrap both ways, both branch outcomes, halt
  task automatic test_directed_ops();
    send_instr(FN_WRITE, 8'h00, '0,           8'h00, 1'b0);
    send_instr(FN_JMPZ,  8'hFF, 32'hFFFFFFFF, 8'hFF, 1'b1);
    send_instr(FN_JMPNZ, 8'h00, 32'h12345678, 8'h00, 1'b0);
    // pointer already at zero, decrease by nothing is legal
    send_instr(FN_DECP,  8'h00, '0,           8'h00, 1'b0);
    send_instr(FN_INCV,  8'hFF, '0,           8'h00, 1'b0);
    // add wraps past 255
    send_instr(FN_INCV,  8'h01, '0,           8'h00, 1'b0);
    // subtract wraps below zero
    send_instr(FN_DECV,  8'h01, '0,           8'h00, 1'b0);
    send_instr(FN_JMPNZ, 8'h00, 32'hFFFFFFFF, 8'h00, 1'b0);
    send_instr(FN_JMPZ,  8'h00, 32'hAAAAAAAA, 8'h00, 1'b0);
    send_instr(FN_DECV,  8'hFF, '0,           8'h00, 1'b0);
    send_instr(FN_INCV,  8'h00, '0,           8'h00, 1'b0);
    send_instr(FN_READ,  8'h00, '0,           8'hFF, 1'b0);
    send_instr(FN_WRITE, 8'h00, '0,           8'h00, 1'b0);
    send_instr(FN_READ,  8'h00, '0,           8'h00, 1'b0);
    send_instr(FN_INCP,  8'hFF, '0,           8'h00, 1'b0);
    send_instr(FN_READ,  8'h00, '0,           8'hA5, 1'b0);
    // decrease by exactly the pointer lands on zero without underflow
    send_instr(FN_DECP,  8'hFF, '0,           8'h00, 1'b0);
    send_instr(FN_INCP,  8'h01, '0,           8'h00, 1'b1);
    send_instr(FN_DEBUG, 8'h5A, 32'h55555555, 8'h5A, 1'b1);
    send_instr(FN_RET,   8'h00, '0,           8'h00, 1'b0);
    send_instr(FN_DECP,  8'h01, '0,           8'h00, 1'b0);
    send_instr(FN_JMPZ,  8'h00, 32'h55555555, 8'h00, 1'b0);
    send_instr(FN_INCP,  8'h00, '0,           8'h00, 1'b0);
  endtask

  // walk to the last cell and back, with cell work on the way
  task automatic test_tape_sweep();
    cell_t amt;
    while (model_ptr != PTR_LAST) begin
      if ($urandom_range(0, 3) == 0) send_legal_op();
      else begin
        amt = ($urandom_range(0, 3) == 0) ? pick_step(PTR_LAST - model_ptr)
                                          : cell_t'(((PTR_LAST - model_ptr) < 255) ?
                                                    (PTR_LAST - model_ptr) : 255);
        send_instr(FN_INCP, amt, '0, pick_byte(), 1'($urandom));
      end
    end
    // at the top: zero step, cell work, then back down
    send_instr(FN_INCP,  8'h00, '0, 8'h00, 1'b0);
    send_instr(FN_READ,  8'h00, '0, 8'h3C, 1'b0);
    send_instr(FN_WRITE, 8'h00, '0, 8'h00, 1'b0);
    send_instr(FN_JMPNZ, 8'h00, pick_target(), 8'h00, 1'b0);
    send_instr(FN_DECV,  8'h3C, '0, 8'h00, 1'b0);
    send_instr(FN_JMPZ,  8'h00, pick_target(), 8'h00, 1'b0);
    while (model_ptr != '0) begin
      if ($urandom_range(0, 3) == 0) send_legal_op();
      else begin
        amt = ($urandom_range(0, 3) == 0) ? pick_step(model_ptr)
                                          : cell_t'((model_ptr < 255) ? model_ptr : 255);
        send_instr(FN_DECP, amt, '0, pick_byte(), 1'($urandom));
      end
    end
  endtask

  // legal random programs; stretches of steady flow and full drains mixed in
  task automatic test_random_program();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) steady_flow = ($urandom_range(0, 4) == 0);
      if (n % 500 == 250) wait_results_drained();
      send_legal_op();
    end
    steady_flow = 1'b0;
  endtask

  // raise one error at its exact boundary, then check that it sticks
  task automatic test_sticky_error();
    err_t kind;
    kind = err_t'($urandom_range(ERR_PTR_OVF, ERR_INVALID));
    case (kind)
      ERR_PTR_OVF: begin
        while (model_ptr + 255 < TAPE_CELLS)
          send_instr(FN_INCP, 8'hFF, '0, pick_byte(), 1'b0);
        // smallest step that reaches the end of the tape
        send_instr(FN_INCP, cell_t'(TAPE_CELLS - model_ptr), '0, 8'h00, 1'b0);
      end
      ERR_PTR_UNF: begin
        while (model_ptr > 254)
          send_instr(FN_DECP, 8'hFF, '0, pick_byte(), 1'b0);
        // one more than the pointer
        send_instr(FN_DECP, cell_t'(model_ptr + 1), '0, 8'h00, 1'b0);
      end
      ERR_EOF: send_instr(FN_READ, 8'h00, '0, pick_byte(), 1'b1);
      default: send_instr(func_t'($urandom_range(FN_INVALID_LO, 15)), pick_byte(),
                          pick_target(), pick_byte(), 1'($urandom));
    endcase
    // every code, valid or not, must now leave the state alone
    for (int n = 0; n < 48; n++)
      send_instr(func_t'(n % 16), pick_byte(), pick_target(), pick_byte(), 1'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // result side: random backpressure
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (steady_flow || $urandom_range(0, 9) < 7) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check: each transaction against the oldest owed result
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result transaction with nothing owed, pointer %0h cell %0h",
                 $time, res_if.pointer, res_if.cell_res);
        fault_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_valid",     want.out_valid,     res_if.out_valid);
        check_field("out_byte",      want.out_byte,      res_if.out_byte);
        check_field("branch_taken",  want.branch_taken,  res_if.branch_taken);
        check_field("branch_target", want.branch_target, res_if.branch_target);
        check_field("error_code",    want.error_code,    res_if.error_code);
        check_field("halted",        want.halted,        res_if.halted);
        check_field("pointer",       want.pointer,       res_if.pointer);
        check_field("cell_res",      want.cell_res,      res_if.cell_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    fault_count      = 0;
    steady_flow      = 1'b0;
    model_ptr        = '0;
    model_err        = ERR_NONE;
    instr_if.valid   = 1'b0;
    instr_if.func    = FN_DEBUG;
    instr_if.amount  = '0;
    instr_if.target  = '0;
    instr_if.in_byte = '0;
    instr_if.in_eof  = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // the first send waits out the tape clear through ready
    test_directed_ops();
    test_tape_sweep();
    test_random_program();
    test_sticky_error();

    // drain, then give stray results a chance to show up
    idle_instr();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("tape_machine_instruction_executor_core test passed");
    end else begin
      $display("tape_machine_instruction_executor_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tmie_pkg.sv
rtl/tmie_if.sv
rtl/tmie_front.sv
rtl/tmie_tape.sv
rtl/tape_machine_instruction_executor_core.sv
tb/sv/tb_tape_machine_instruction_executor_core.sv
